// File: hdl/s32tv_pkg.sv
`default_nettype none

package s32tv_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAG_W   = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned OUT_W   = 40;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [MAG_W-1:0] MAG_SAT   = 32'hFFFF_FFFF;
  localparam logic [MAG_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [MAG_W-1:0] NEG_LIMIT = 32'h8000_0000;

  typedef enum logic [1:0] {
    PH_START     = 2'd0,
    PH_SIGN      = 2'd1,
    PH_BODY      = 2'd2,
    PH_LONE_ZERO = 2'd3
  } phase_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_USE  = 2'd1,
    ST_BAD_DIGIT = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef struct packed {
    phase_t            phase;
    logic              is_negative;
    logic              zero_fault;
    logic              digit_fault;
    logic [MAG_W-1:0]  magnitude;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:       PH_START,
    is_negative: 1'b0,
    zero_fault:  1'b0,
    digit_fault: 1'b0,
    magnitude:   '0
  };

  typedef struct packed {
    status_t           status;
    logic [MAG_W-1:0]  value;
  } parse_result_t;

endpackage

`default_nettype wire

// File: hdl/s32tv_step.sv
`default_nettype none

module s32tv_step
  import s32tv_pkg::*;
(
  input  wire logic [CHAR_W-1:0] char_code,
  input  wire parse_state_t      st,
  output parse_state_t           st_nxt,
  output logic                   is_term,
  output parse_result_t          result
);

  logic              is_digit;
  logic [3:0]        digit_val;
  logic [MAG_W+3:0]  mag_x10;
  logic [MAG_W+3:0]  mag_sum;
  logic [MAG_W-1:0]  mag_acc;
  logic              over_range;

  assign is_term   = (char_code == CH_NUL);
  assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign digit_val = 4'(char_code - CH_ZERO);

  // m*10 = (m<<3) + (m<<1)
  assign mag_x10 = {1'b0, st.magnitude, 3'b000} + {3'b000, st.magnitude, 1'b0};
  assign mag_sum = mag_x10 + {{MAG_W{1'b0}}, digit_val};
  assign mag_acc = (mag_sum[MAG_W+3:MAG_W] != '0) ? MAG_SAT : mag_sum[MAG_W-1:0];

  assign over_range = st.is_negative ? (st.magnitude > NEG_LIMIT)
                                     : (st.magnitude > POS_LIMIT);

  always_comb begin
    st_nxt = st;
    if (is_term) begin
      st_nxt = STATE_RESET;
    end else begin
      case (st.phase)
        PH_START: begin
          if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
            st_nxt.is_negative = (char_code == CH_MINUS);
            st_nxt.phase       = PH_SIGN;
          end else if (char_code == CH_ZERO) begin
            st_nxt.phase = PH_LONE_ZERO;
          end else begin
            st_nxt.phase = PH_BODY;
          end
        end
        PH_SIGN: begin
          if (char_code == CH_ZERO) begin
            st_nxt.zero_fault = 1'b1;
          end
          st_nxt.phase = PH_BODY;
        end
        PH_LONE_ZERO: begin
          st_nxt.zero_fault = 1'b1;
          st_nxt.phase      = PH_BODY;
        end
        default: begin
          st_nxt.phase = PH_BODY;
        end
      endcase
      // sign and first zero do not accumulate
      if (st_nxt.phase == PH_BODY) begin
        if (is_digit) begin
          st_nxt.magnitude = mag_acc;
        end else begin
          st_nxt.digit_fault = 1'b1;
        end
      end
    end
  end

  always_comb begin
    result.value = '0;
    if (st.zero_fault) begin
      result.status = ST_ZERO_USE;
    end else if (st.digit_fault || (st.phase == PH_START) || (st.phase == PH_SIGN)) begin
      result.status = ST_BAD_DIGIT;
    end else if (over_range) begin
      result.status = ST_RANGE;
    end else begin
      result.status = ST_OK;
      result.value  = st.is_negative ? (MAG_W'(0) - st.magnitude) : st.magnitude;
    end
  end

endmodule

`default_nettype wire

// File: hdl/signed_int32_token_validator.sv
`default_nettype none

// Parses a signed decimal token arriving one ASCII character per transaction;
// a NUL character ends the token and produces one result transaction with a
// status (ok, misused zero, bad digit or empty, outside int32) and the int32
// value, which is zero unless the status is ok. One character is taken every cycle,
// save a NUL behind a pending result; a NUL is held in the input register, then its
// result in the result register. The combinational multiply-by-ten accumulate between
// the input register and the token state register keeps up one character per cycle.
// A pending result only stalls a following NUL, never the characters in between.

module signed_int32_token_validator
  import s32tv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [CHAR_W-1:0] in_tdata,   // [7:0] char_code
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_W-1:0]       out_tdata   // [1:0] status, [33:2] value, rest zero
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [CHAR_W-1:0]  s1_char_r;
  parse_state_t       st_r;
  parse_state_t       st_nxt;
  parse_state_t       step_nxt;
  logic               step_term;
  parse_result_t      step_res;
  logic               out_valid_r;
  logic               out_valid_nxt;
  parse_result_t      out_res_r;
  logic               in_accept;
  logic               adv;

  s32tv_step u_step (
    .char_code (s1_char_r),
    .st        (st_r),
    .st_nxt    (step_nxt),
    .is_term   (step_term),
    .result    (step_res)
  );

  assign adv       = s1_valid_r && (!step_term || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      s1_valid_nxt = 1'b0;
      st_nxt       = step_nxt;
    end
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (adv && step_term) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_tdata;
    end
    if (adv && step_term) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - MAG_W - STAT_W){1'b0}}, out_res_r.value, out_res_r.status};

  a_fault_zero_value : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_res_r.status != ST_OK)) |-> (out_res_r.value == '0))
    else $error("non-ok result carries a nonzero value");

  a_term_clears_state : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && step_term) |=> ((st_r.phase == PH_START) && (st_r.magnitude == '0)
                            && !st_r.zero_fault && !st_r.digit_fault))
    else $error("token state not cleared after terminator");

  a_zero_fault_in_body : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.zero_fault |-> (st_r.phase == PH_BODY))
    else $error("zero fault outside token body");

  a_no_result_overrun : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(adv && step_term))
    else $error("result register overwritten while pending");

endmodule

`default_nettype wire

// File: tb/s32tv_parse_monitor.sv
module s32tv_parse_monitor
  import s32tv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tready,
  input  wire logic [CHAR_W-1:0] in_tdata,   // [7:0] char_code
  input  wire logic              out_tvalid,
  input  wire logic              out_tready,
  input  wire logic [OUT_W-1:0]  out_tdata,  // [1:0] status, [33:2] value, rest zero
  output int                     fail_count,
  output int                     pending_count,
  output int                     results_checked,
  output int                     ok_count,
  output int                     zero_use_count,
  output int                     bad_digit_count,
  output int                     range_count
);

  localparam logic [63:0] RADIX = 64'd10;

  parse_state_t  tok;
  parse_result_t expected_results [$];
  int            fails = 0;
  int            tally [4] = '{0, 0, 0, 0};
  int            checked = 0;

  function automatic void add_digit(input logic [CHAR_W-1:0] c);
    logic [63:0] wide;
    if (c < CH_ZERO || c > CH_NINE) begin
      tok.digit_fault = 1'b1;
      return;
    end
    wide = 64'(tok.magnitude) * RADIX + (64'(c) - 64'(CH_ZERO));
    if (wide > 64'(MAG_SAT)) tok.magnitude = MAG_SAT;
    else tok.magnitude = wide[MAG_W-1:0];
  endfunction

  // Advances the token state by one character; returns 1 with the result on NUL.
  function automatic bit parse_char(input logic [CHAR_W-1:0] c, output parse_result_t r);
    r = '0;
    r.status = ST_OK;
    if (c != CH_NUL) begin
      case (tok.phase)
        PH_START: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            tok.is_negative = (c == CH_MINUS);
            tok.phase = PH_SIGN;
          end else if (c == CH_ZERO) begin
            tok.phase = PH_LONE_ZERO;
          end else begin
            add_digit(c);
            tok.phase = PH_BODY;
          end
        end
        PH_SIGN: begin
          if (c == CH_ZERO) tok.zero_fault = 1'b1;
          add_digit(c);
          tok.phase = PH_BODY;
        end
        PH_LONE_ZERO: begin
          tok.zero_fault = 1'b1;
          add_digit(c);
          tok.phase = PH_BODY;
        end
        default: begin
          add_digit(c);
        end
      endcase
      return 1'b0;
    end
    if (tok.zero_fault) begin
      r.status = ST_ZERO_USE;
    end else if (tok.digit_fault || tok.phase == PH_START || tok.phase == PH_SIGN) begin
      r.status = ST_BAD_DIGIT;
    end else if (tok.is_negative ? (tok.magnitude > NEG_LIMIT)
                                 : (tok.magnitude > POS_LIMIT)) begin
      r.status = ST_RANGE;
    end else begin
      r.status = ST_OK;
      r.value  = tok.is_negative ? (MAG_W'(0) - tok.magnitude) : tok.magnitude;
    end
    tok = STATE_RESET;
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    parse_result_t      want;
    logic [STAT_W-1:0]  got_status;
    logic [MAG_W-1:0]   got_value;
    if (!rst_n) begin
      tok = STATE_RESET;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_char(in_tdata, want)) expected_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing pending: tdata %h", out_tdata);
          fails++;
        end else begin
          want       = expected_results.pop_front();
          got_status = out_tdata[STAT_W-1:0];
          got_value  = out_tdata[STAT_W+MAG_W-1:STAT_W];
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            fails++;
          end
          if (got_value !== want.value) begin
            $error("value: expected %0d, got %0d", $signed(want.value), $signed(got_value));
            fails++;
          end
          if (out_tdata[OUT_W-1:STAT_W+MAG_W] !== '0) begin
            $error("pad: expected 0, got %h", out_tdata[OUT_W-1:STAT_W+MAG_W]);
            fails++;
          end
          tally[want.status]++;
          checked++;
        end
      end
    end
    fail_count      <= fails;
    pending_count   <= expected_results.size();
    results_checked <= checked;
    ok_count        <= tally[ST_OK];
    zero_use_count  <= tally[ST_ZERO_USE];
    bad_digit_count <= tally[ST_BAD_DIGIT];
    range_count     <= tally[ST_RANGE];
  end

endmodule

// File: tb/tb_signed_int32_token_validator.sv
module tb_signed_int32_token_validator
  import s32tv_pkg::*;
();

  localparam int CHAR_TARGET    = 1500;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_AFTER     = 30;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [CHAR_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;

  int fail_count;
  int pending_count;
  int results_checked;
  int ok_count;
  int zero_use_count;
  int bad_digit_count;
  int range_count;

  logic [CHAR_W-1:0] token_chars [$];
  bit src_burst  = 1'b0;
  bit sink_burst = 1'b0;
  int chars_sent  = 0;
  int tokens_sent = 0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  signed_int32_token_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  s32tv_parse_monitor monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending_count   (pending_count),
    .results_checked (results_checked),
    .ok_count        (ok_count),
    .zero_use_count  (zero_use_count),
    .bad_digit_count (bad_digit_count),
    .range_count     (range_count)
  );

  task automatic send_char(input logic [CHAR_W-1:0] c);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_token();
    src_burst = ($urandom_range(0, 3) == 0);
    foreach (token_chars[i]) send_char(token_chars[i]);
    send_char(CH_NUL);
    token_chars.delete();
    tokens_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) token_chars.push_back(CHAR_W'(s[i]));
  endtask

  task automatic push_decimal(input longint unsigned v);
    logic [CHAR_W-1:0] digits [$];
    do begin
      digits.push_front(CH_ZERO + CHAR_W'(v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digits[i]) token_chars.push_back(digits[i]);
  endtask

  // Digit string with a nonzero lead digit.
  task automatic push_digits(input int n);
    token_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(1, 9)));
    for (int i = 1; i < n; i++) token_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
  endtask

  task automatic push_sign(input int s);
    if (s == 1) token_chars.push_back(CH_PLUS);
    else if (s == 2) token_chars.push_back(CH_MINUS);
  endtask

  initial begin : stimulus
    int kind;
    int sub;
    int sgn;
    int n;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= CH_NUL;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, sign alone, lone zero, sign then zero, leading zero,
    // second sign, top code, most negative value
    send_token();
    push_text("-");
    send_token();
    push_text("0");
    send_token();
    push_text("-0");
    send_token();
    push_text("05");
    send_token();
    push_text("+-");
    send_token();
    token_chars.push_back(8'hFF);
    send_token();
    push_text("-");
    push_decimal(64'd2147483648);
    send_token();

    while (chars_sent < CHAR_TARGET) begin
      kind = $urandom_range(0, 99);
      sgn  = $urandom_range(0, 2);
      if (kind < 50) begin
        push_sign(sgn);
        sub = $urandom_range(0, 9);
        if (sub < 5) begin
          push_digits($urandom_range(1, 10));
        end else if (sub < 8) begin
          case ($urandom_range(0, 7))
            0: push_decimal(64'd2147483646);
            1: push_decimal(64'd2147483647);
            2: push_decimal(64'd2147483648);
            3: push_decimal(64'd2147483649);
            4: push_decimal(64'd4294967295);
            5: push_decimal(64'd4294967296);
            6: push_decimal(64'd42949672950);
            default: push_decimal(64'd1);
          endcase
        end else if (sub == 8) begin
          push_digits($urandom_range(11, 20));
        end else if (sgn == 0) begin
          token_chars.push_back(CH_ZERO);
        end else begin
          push_digits(1);
        end
      end else if (kind < 65) begin
        push_sign(sgn);
        token_chars.push_back(CH_ZERO);
        n = $urandom_range((sgn != 0) ? 0 : 1, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) token_chars.push_back(CHAR_W'($urandom_range(1, 255)));
          else token_chars.push_back(CH_ZERO + CHAR_W'($urandom_range(0, 9)));
        end
      end else if (kind < 80) begin
        push_sign(sgn);
        push_digits($urandom_range(1, 8));
        token_chars.insert($urandom_range(0, token_chars.size()),
                           CHAR_W'($urandom_range(1, 255)));
      end else if (kind < 90) begin
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) token_chars.push_back(CHAR_W'($urandom_range(1, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0: push_text("+");
          1: push_text("-");
          2: push_text("++");
          3: push_text("-+5");
          default: ;
        endcase
      end
      send_token();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d characters in %0d tokens, %0d results compared",
             chars_sent, tokens_sent, results_checked);
    $display("summary: ok %0d, zero misuse %0d, bad digit or empty %0d, out of range %0d",
             ok_count, zero_use_count, bad_digit_count, range_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_signed_int32_token_validator: done, clean");
    end else begin
      $display("tb_signed_int32_token_validator: done, errors");
    end
    $finish;
  end

  // Result side; one long hold-off lets the input back up behind a pending result.
  initial begin : receiver
    int gap;
    int taken;
    taken = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
      else if (sink_burst) gap = 0;
      else gap = $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
      if (taken % 8 == 0) sink_burst = ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_signed_int32_token_validator: done, errors");
      $finish;
    end
  end

endmodule
